@@ rtl/abdma_pkg.sv @@
// abdma_pkg: shared types and constants for the audio block dma sequencer
// no dependencies; used by every module under rtl/
package abdma_pkg;

   // field widths
   localparam int ADDR_W      = 26;
   localparam int COUNT_W     = 15;
   localparam int HIGH_W      = 10;
   localparam int OFFSET_W    = 4;
   localparam int DATA_W      = 16;
   localparam int ALIGN_BITS  = 5;
   localparam int LOW_W       = DATA_W - ALIGN_BITS;

   // control word layout
   localparam int ENABLE_BIT  = 15;

   // block stride in bytes
   localparam logic [ADDR_W-1:0] BLOCK_BYTES = ADDR_W'(32);

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // register offsets
   localparam logic [OFFSET_W-1:0] OFF_START_HIGH = 4'd0;
   localparam logic [OFFSET_W-1:0] OFF_START_LOW  = 4'd2;
   localparam logic [OFFSET_W-1:0] OFF_CONTROL    = 4'd6;

   // input beat
   typedef struct packed {
      logic                cmd;
      logic [OFFSET_W-1:0] reg_offset;
      logic [DATA_W-1:0]   write_data;
   } req_type;

   // result beat
   typedef struct packed {
      logic [ADDR_W-1:0]  block_address;
      logic               zero_fill;
      logic               interrupt_raise;
      logic [COUNT_W-1:0] blocks_remaining;
   } rsp_type;

endpackage

@@ rtl/abdma_regs.sv @@
// abdma_regs: register file, block counter and address sequencer
// depends on abdma_pkg
module abdma_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  abdma_pkg::req_type item,
   output abdma_pkg::rsp_type result
);

   logic [abdma_pkg::HIGH_W-1:0]  start_high_ff, start_high_in;
   logic [abdma_pkg::LOW_W-1:0]   start_low_ff,  start_low_in;
   logic [abdma_pkg::DATA_W-1:0]  control_ff,    control_in;
   logic [abdma_pkg::ADDR_W-1:0]  base_ff,       base_in;
   logic [abdma_pkg::ADDR_W-1:0]  cur_ff,        cur_in;
   logic [abdma_pkg::COUNT_W-1:0] count_ff,      count_in;

   logic                          enabled;
   logic                          is_tick;
   logic                          wrap;
   logic [abdma_pkg::ADDR_W-1:0]  latched_start;

   assign enabled       = control_ff[abdma_pkg::ENABLE_BIT];
   assign is_tick       = (item.cmd == abdma_pkg::CMD_TICK);
   assign latched_start = {start_high_ff, start_low_ff, {abdma_pkg::ALIGN_BITS{1'b0}}};
   // count of zero or one ends the run on this tick
   assign wrap          = (count_ff <= abdma_pkg::COUNT_W'(1));

   // next state
   always_comb begin
      start_high_in = start_high_ff;
      start_low_in  = start_low_ff;
      control_in    = control_ff;
      base_in       = base_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      if (go && !is_tick) begin
         unique case (item.reg_offset)
            abdma_pkg::OFF_START_HIGH: begin
               start_high_in = item.write_data[abdma_pkg::HIGH_W-1:0];
            end
            abdma_pkg::OFF_START_LOW: begin
               start_low_in = item.write_data[abdma_pkg::DATA_W-1:abdma_pkg::ALIGN_BITS];
            end
            abdma_pkg::OFF_CONTROL: begin
               control_in = item.write_data;
               // rising edge of enable latches the start address and count
               if (!enabled && item.write_data[abdma_pkg::ENABLE_BIT]) begin
                  base_in  = latched_start;
                  cur_in   = latched_start;
                  count_in = item.write_data[abdma_pkg::COUNT_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end else if (go && is_tick && enabled) begin
         if (wrap) begin
            cur_in   = base_ff;
            count_in = control_ff[abdma_pkg::COUNT_W-1:0];
         end else begin
            cur_in   = cur_ff + abdma_pkg::BLOCK_BYTES;
            count_in = count_ff - abdma_pkg::COUNT_W'(1);
         end
      end
   end

   // result of a tick
   always_comb begin
      if (enabled) begin
         result.block_address    = cur_ff;
         result.zero_fill        = 1'b0;
         result.interrupt_raise  = wrap;
         result.blocks_remaining = wrap ? control_ff[abdma_pkg::COUNT_W-1:0]
                                        : count_ff - abdma_pkg::COUNT_W'(1);
      end else begin
         result.block_address    = '0;
         result.zero_fill        = 1'b1;
         result.interrupt_raise  = 1'b0;
         result.blocks_remaining = count_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_high_ff <= '0;
         start_low_ff  <= '0;
         control_ff    <= '0;
         base_ff       <= '0;
         cur_ff        <= '0;
         count_ff      <= '0;
      end else begin
         start_high_ff <= start_high_in;
         start_low_ff  <= start_low_in;
         control_ff    <= control_in;
         base_ff       <= base_in;
         cur_ff        <= cur_in;
         count_ff      <= count_in;
      end
   end

   // disabled tick leaves the counter alone
   assert property (@(posedge clock) disable iff (reset)
      go && is_tick && !enabled |=> $stable(count_ff) && $stable(cur_ff))
      else $error("disabled tick changed the sequencer state");

   // a wrap reloads the address from the base
   assert property (@(posedge clock) disable iff (reset)
      go && is_tick && enabled && wrap |=> cur_ff == base_ff)
      else $error("wrap did not reload the base address");

   // an ordinary tick steps the count down by one
   assert property (@(posedge clock) disable iff (reset)
      go && is_tick && enabled && !wrap |=>
         count_ff == $past(count_ff) - abdma_pkg::COUNT_W'(1))
      else $error("tick did not decrement the block count");

endmodule

@@ rtl/abdma_out.sv @@
// abdma_out: result register holding one beat for the rsp channel
// depends on abdma_pkg
module abdma_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  abdma_pkg::rsp_type load_data,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output abdma_pkg::rsp_type rsp_data
);

   logic               valid_ff, valid_in;
   abdma_pkg::rsp_type data_ff, data_in;

   // slot is free when empty or being drained this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ rtl/audio_block_dma_sequencer.sv @@
// audio_block_dma_sequencer: top level; input register, sequencer, result register
// depends on abdma_pkg, abdma_regs, abdma_out
// path: a tick beat goes through the input register, then the result register, to rsp
// throughput: one beat per cycle; writes never wait, ticks wait on a full, stalled result reg
// reset: synchronous, clears the sequencer state to zero and empties both stages
module audio_block_dma_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  abdma_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output abdma_pkg::rsp_type rsp_data
);

   logic               s1_valid_ff, s1_valid_in;
   abdma_pkg::req_type s1_data_ff,  s1_data_in;
   logic               s1_go;
   logic               s1_tick;
   logic               out_free;
   abdma_pkg::rsp_type result;

   // a write always retires; a tick needs room in the result register
   assign s1_tick   = (s1_data_ff.cmd == abdma_pkg::CMD_TICK);
   assign s1_go     = s1_valid_ff && (!s1_tick || out_free);
   assign req_stall = s1_valid_ff && !s1_go;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_data_ff <= s1_data_in;
   end

   // sequencer state and tick result
   abdma_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .go     (s1_go),
      .item   (s1_data_ff),
      .result (result)
   );

   // result register
   abdma_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_go && s1_tick),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
